FILE: rtl/lzwvwd_pkg.sv
`default_nettype none

package lzwvwd_pkg;

  // Widest code the dictionary may hand out
  localparam int MAX_BITS = 12;

  localparam int CODE_W  = 12;
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 3;
  localparam int CWID_W  = 4;
  localparam int WNOW_W  = 5;
  localparam int NFC_W   = 13;
  localparam int CNT_W   = 7;

  localparam int STORE_DEPTH = 4096;
  localparam int DICT_W      = CODE_W + BYTE_W;

  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_CODE   = 1'b1;

  localparam logic [CODE_W-1:0] CODE_END   = CODE_W'(256);
  localparam logic [CODE_W-1:0] CODE_BUMP  = CODE_W'(257);
  localparam logic [CODE_W-1:0] CODE_FLUSH = CODE_W'(258);
  localparam logic [NFC_W-1:0]  CODE_FIRST = NFC_W'(259);

  localparam logic [WNOW_W-1:0] WIDTH_START = WNOW_W'(9);
  localparam logic [WNOW_W-1:0] WIDTH_MAX   = WNOW_W'(MAX_BITS);

  localparam logic [NFC_W-1:0] TABLE_LIMIT =
    (MAX_BITS >= 12) ? NFC_W'(4096) : NFC_W'(1 << MAX_BITS);

  localparam logic [NFC_W-1:0] LEN_MAX   = NFC_W'(64);
  localparam logic [NFC_W-1:0] LEN_TRUNC = NFC_W'(63);
  localparam logic [NFC_W-1:0] LEN_STOP  = NFC_W'(STORE_DEPTH - 1);

  localparam logic [KIND_W-1:0] KIND_DATA  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WIDTH = 3'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MISS  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CAP   = 3'd4;

endpackage

`default_nettype wire

FILE: rtl/lzwvwd_in_if.sv
`default_nettype none

interface lzwvwd_in_if;
  import lzwvwd_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [CODE_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

FILE: rtl/lzwvwd_out_if.sv
`default_nettype none

interface lzwvwd_out_if;
  import lzwvwd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic [KIND_W-1:0] kind;
  logic              last;
  logic [CWID_W-1:0] code_width;

  modport source (output valid, output data_byte, output kind, output last,
                  output code_width, input ready);
  modport sink   (input valid, input data_byte, input kind, input last,
                  input code_width, output ready);
endinterface

`default_nettype wire

FILE: rtl/lzwvwd_ram.sv
`default_nettype none

module lzwvwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/lzw_variable_width_decoder_unit.sv
`default_nettype none

// Variable-width LZW decoder fed with codes already cut from the bit stream.
// A header item sets the code width; code 256 ends the stream, 257 widens
// codes by one bit up to 12, 258 empties the dictionary and returns to 9
// bits. Each other code is expanded by walking its parent chain through the
// dictionary RAM one entry per cycle, pushing bytes onto a stack RAM, then
// popping them first to last at one result per cycle while the sink is
// ready. Header, bump, flush, end and missing-previous items each yield a
// single result. The walk through the single dictionary read port sets the
// pace. Strings over 64 bytes, or a full table, end with a capacity result
// after at most 63 bytes. Neither RAM is cleared after reset: the dictionary
// is only read at entries that the stream wrote.
module lzw_variable_width_decoder_unit (
  input wire logic    clk,
  input wire logic    rst_n,
  lzwvwd_in_if.sink   in_ch,
  lzwvwd_out_if.source out_ch
);
  import lzwvwd_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHAIN  = 3'd1;
  localparam logic [2:0] ST_WALK   = 3'd2;
  localparam logic [2:0] ST_FIN    = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;
  localparam logic [2:0] ST_FLAG   = 3'd5;
  localparam logic [2:0] ST_RESULT = 3'd6;

  localparam int PTR_W = $clog2(STORE_DEPTH);

  logic [2:0]        state_r, state_nxt;
  logic [NFC_W-1:0]  next_free_r, next_free_nxt;
  logic [WNOW_W-1:0] width_r, width_nxt;
  logic [CODE_W-1:0] prev_code_r, prev_code_nxt;
  logic              prev_valid_r, prev_valid_nxt;
  logic [BYTE_W-1:0] first_last_r, first_last_nxt;
  logic [CODE_W-1:0] cur_code_r, cur_code_nxt;
  logic [CODE_W-1:0] c_r, c_nxt;
  logic [NFC_W-1:0]  n_r, n_nxt;
  logic [BYTE_W-1:0] first_r, first_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  remain_r, remain_nxt;
  logic              flag_r, flag_nxt;
  logic [KIND_W-1:0] res_kind_r, res_kind_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic              out_last_r, out_last_nxt;
  logic [CWID_W-1:0] out_width_r, out_width_nxt;

  logic              dict_re, dict_we;
  logic [PTR_W-1:0]  dict_raddr, dict_waddr;
  logic [DICT_W-1:0] dict_wdata, dict_rdata;
  logic [CODE_W-1:0] parent;
  logic [BYTE_W-1:0] suffix;

  logic              stk_we, stk_re;
  logic [PTR_W-1:0]  stk_waddr;
  logic [BYTE_W-1:0] stk_wdata, stk_rdata;

  logic              slot_free;
  logic              table_full;
  logic              flag_now;

  assign parent     = dict_rdata[DICT_W-1:BYTE_W];
  assign suffix     = dict_rdata[BYTE_W-1:0];
  assign slot_free  = !out_valid_r || out_ch.ready;
  assign table_full = next_free_r >= TABLE_LIMIT;
  assign flag_now   = (prev_valid_r && table_full) || (n_r > LEN_MAX);

  lzwvwd_ram #(.WIDTH(DICT_W), .DEPTH(STORE_DEPTH)) u_dict (
    .clk   (clk),
    .we    (dict_we),
    .waddr (dict_waddr),
    .wdata (dict_wdata),
    .re    (dict_re),
    .raddr (dict_raddr),
    .rdata (dict_rdata)
  );

  lzwvwd_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (rd_ptr_r),
    .rdata (stk_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    next_free_nxt  = next_free_r;
    width_nxt      = width_r;
    prev_code_nxt  = prev_code_r;
    prev_valid_nxt = prev_valid_r;
    first_last_nxt = first_last_r;
    cur_code_nxt   = cur_code_r;
    c_nxt          = c_r;
    n_nxt          = n_r;
    first_nxt      = first_r;
    rd_ptr_nxt     = rd_ptr_r;
    remain_nxt     = remain_r;
    flag_nxt       = flag_r;
    res_kind_nxt   = res_kind_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_kind_nxt   = out_kind_r;
    out_last_nxt   = out_last_r;
    out_width_nxt  = out_width_r;

    dict_re    = 1'b0;
    dict_raddr = c_r;
    dict_we    = 1'b0;
    dict_waddr = next_free_r[PTR_W-1:0];
    dict_wdata = {prev_code_r, first_r};
    stk_we     = 1'b0;
    stk_waddr  = n_r[PTR_W-1:0];
    stk_wdata  = c_r[BYTE_W-1:0];
    stk_re     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cur_code_nxt = in_ch.value;
          state_nxt    = ST_RESULT;
          res_kind_nxt = KIND_WIDTH;
          if (in_ch.cmd == CMD_HEADER) begin
            if (in_ch.value < CODE_W'(WIDTH_START)) begin
              width_nxt = WIDTH_START;
            end else if (in_ch.value > CODE_W'(WIDTH_MAX)) begin
              width_nxt = WIDTH_MAX;
            end else begin
              width_nxt = in_ch.value[WNOW_W-1:0];
            end
            prev_valid_nxt = 1'b0;
          end else if (in_ch.value == CODE_END) begin
            res_kind_nxt = KIND_END;
          end else if (in_ch.value == CODE_FLUSH) begin
            next_free_nxt  = CODE_FIRST;
            width_nxt      = WIDTH_START;
            prev_valid_nxt = 1'b0;
          end else if (in_ch.value == CODE_BUMP) begin
            if (width_r < WIDTH_MAX) begin
              width_nxt = width_r + WNOW_W'(1);
            end
          end else if ({1'b0, in_ch.value} >= next_free_r) begin
            if (!prev_valid_r) begin
              res_kind_nxt = KIND_MISS;
            end else begin
              // code not yet defined: previous string plus its own first byte
              stk_we    = 1'b1;
              stk_waddr = '0;
              stk_wdata = first_last_r;
              first_nxt = first_last_r;
              n_nxt     = NFC_W'(1);
              c_nxt     = prev_code_r;
              state_nxt = ST_CHAIN;
            end
          end else begin
            n_nxt     = '0;
            c_nxt     = in_ch.value;
            state_nxt = ST_CHAIN;
          end
        end
      end

      ST_CHAIN: begin
        if (c_r[CODE_W-1:BYTE_W] == '0) begin
          // root byte closes the chain
          stk_we    = 1'b1;
          stk_wdata = c_r[BYTE_W-1:0];
          first_nxt = c_r[BYTE_W-1:0];
          n_nxt     = n_r + NFC_W'(1);
          state_nxt = ST_FIN;
        end else begin
          dict_re   = 1'b1;
          state_nxt = ST_WALK;
        end
      end

      ST_WALK: begin
        stk_we    = 1'b1;
        stk_wdata = suffix;
        first_nxt = suffix;
        n_nxt     = n_r + NFC_W'(1);
        if (n_r == LEN_STOP) begin
          // stack full: stop a looping chain
          state_nxt = ST_FIN;
        end else if (parent[CODE_W-1:BYTE_W] == '0) begin
          c_nxt     = parent;
          state_nxt = ST_CHAIN;
        end else begin
          dict_re    = 1'b1;
          dict_raddr = parent;
        end
      end

      ST_FIN: begin
        if (prev_valid_r && !table_full) begin
          dict_we       = 1'b1;
          next_free_nxt = next_free_r + NFC_W'(1);
        end
        flag_nxt = flag_now;
        if (flag_now && (n_r > LEN_TRUNC)) begin
          remain_nxt = LEN_TRUNC[CNT_W-1:0];
        end else begin
          remain_nxt = n_r[CNT_W-1:0];
        end
        rd_ptr_nxt     = PTR_W'(n_r - NFC_W'(1));
        prev_code_nxt  = cur_code_r;
        prev_valid_nxt = 1'b1;
        first_last_nxt = first_r;
        state_nxt      = ST_EMIT;
      end

      ST_EMIT: begin
        if (slot_free) begin
          stk_re        = 1'b1;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_DATA;
          out_last_nxt  = !flag_r && (remain_r == CNT_W'(1));
          out_width_nxt = width_r[CWID_W-1:0];
          rd_ptr_nxt    = rd_ptr_r - PTR_W'(1);
          remain_nxt    = remain_r - CNT_W'(1);
          if (remain_r == CNT_W'(1)) begin
            state_nxt = flag_r ? ST_FLAG : ST_IDLE;
          end
        end
      end

      ST_FLAG: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_CAP;
          out_last_nxt  = 1'b1;
          out_width_nxt = width_r[CWID_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end

      ST_RESULT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_last_nxt  = 1'b1;
          out_width_nxt = width_r[CWID_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      next_free_r  <= CODE_FIRST;
      width_r      <= WIDTH_START;
      prev_code_r  <= '0;
      prev_valid_r <= 1'b0;
      first_last_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      next_free_r  <= next_free_nxt;
      width_r      <= width_nxt;
      prev_code_r  <= prev_code_nxt;
      prev_valid_r <= prev_valid_nxt;
      first_last_r <= first_last_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_code_r  <= cur_code_nxt;
    c_r         <= c_nxt;
    n_r         <= n_nxt;
    first_r     <= first_nxt;
    rd_ptr_r    <= rd_ptr_nxt;
    remain_r    <= remain_nxt;
    flag_r      <= flag_nxt;
    res_kind_r  <= res_kind_nxt;
    out_kind_r  <= out_kind_nxt;
    out_last_r  <= out_last_nxt;
    out_width_r <= out_width_nxt;
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_kind_r;
  assign out_ch.last       = out_last_r;
  assign out_ch.code_width = out_width_r;
  assign out_ch.data_byte  = (out_kind_r == KIND_DATA) ? stk_rdata : '0;

endmodule

`default_nettype wire
